// ----- rtl/nvme_host_queue_pair_engine_unit_macros.svh -----
// assertion macros used by the checker file
`ifndef NVME_HOST_QUEUE_PAIR_ENGINE_UNIT_MACROS_SVH
`define NVME_HOST_QUEUE_PAIR_ENGINE_UNIT_MACROS_SVH

// checked only out of reset
`define NHQP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define NHQP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/nhqp_pkg.sv -----
// ----------------------------------------------------------------------------
// nhqp_pkg
// shared types and constants of the nvme host queue pair engine
// ----------------------------------------------------------------------------
package nhqp_pkg;

  localparam int DEF_MAX_QUEUE_DEPTH = 16;
  localparam int DEF_PAGE_BYTES      = 4096;
  localparam int FIFO_DEPTH          = 2;

  localparam logic [25:0] DB_BASE = 26'h1000;

  // input function codes
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_COMPL = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_ISSUED   = 2'd0;
  localparam logic [1:0] KIND_REJECTED = 2'd1;
  localparam logic [1:0] KIND_CONSUMED = 2'd2;
  localparam logic [1:0] KIND_STALE    = 2'd3;

  // command opcodes
  localparam logic [1:0] OPC_NONE  = 2'd0;
  localparam logic [1:0] OPC_WRITE = 2'd1;
  localparam logic [1:0] OPC_READ  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_QUEUE_ID   = 2'd0;
  localparam logic [1:0] REG_RING_SIZE  = 2'd1;
  localparam logic [1:0] REG_STRIDE_EXP = 2'd2;
  localparam logic [1:0] REG_BLOCK_LOG2 = 2'd3;

  typedef enum logic [1:0] {
    CLS_SUBMIT,
    CLS_COMPL,
    CLS_BAD
  } cls_e;

  typedef struct packed {
    cls_e        cls;
    logic [1:0]  opcode;
    logic        xfer_ok;
    logic [63:0] lba;
    logic [15:0] cnt_m1;
    logic        phase;
  } entry_t;

  typedef struct packed {
    logic [7:0] queue_id;
    logic [4:0] ring_size;
    logic [3:0] stride_exp;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        db_write;
    logic [25:0] db_offset;
    logic [3:0]  db_value;
    logic [1:0]  opcode;
    logic [15:0] command_id;
    logic [63:0] start_block;
    logic [15:0] cnt_m1;
    logic [3:0]  slot;
  } result_t;

endpackage

// ----- rtl/nvme_host_queue_pair_engine_unit.sv -----
// path: a request beat is written into the two-entry queue, popped by the back
//   end and held in the result register until it is taken
// throughput: one request beat per cycle while the queue is not full; the back
//   end moves all ring pointers together and the two-entry queue absorbs output stalls
// reset: ring pointers, phase, outstanding count and command id go to zero,
//   registers to queue_id 1, ring size 16, stride_exp 0, block_size_log2 9
// ----------------------------------------------------------------------------
// nvme_host_queue_pair_engine_unit
// host side of one nvme i/o submission and completion queue pair
// ----------------------------------------------------------------------------
module nvme_host_queue_pair_engine_unit #(
  parameter int MAX_QUEUE_DEPTH = nhqp_pkg::DEF_MAX_QUEUE_DEPTH,
  parameter int PAGE_BYTES      = nhqp_pkg::DEF_PAGE_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [63:0] lba_i,
  input  logic [15:0] block_count_i,
  input  logic        phase_bit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic        doorbell_write_o,
  output logic [25:0] doorbell_offset_o,
  output logic [3:0]  doorbell_value_o,
  output logic [1:0]  opcode_o,
  output logic [15:0] command_id_o,
  output logic [63:0] start_block_o,
  output logic [15:0] count_minus_one_o,
  output logic [3:0]  slot_o
);
  import nhqp_pkg::*;

  logic [7:0] queue_id_q;
  logic [4:0] ring_size_q;
  logic [3:0] stride_exp_q;
  logic [3:0] block_log2_q;
  logic       cfg_wr;
  cfg_t       cfg;

  entry_t  push_entry, head_entry;
  logic    push, pop, fifo_full, fifo_empty;
  result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_id_q   <= 8'd1;
      ring_size_q  <= 5'd16;
      stride_exp_q <= 4'd0;
      block_log2_q <= 4'd9;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_QUEUE_ID:   queue_id_q   <= pwdata[7:0];
        REG_RING_SIZE:  ring_size_q  <= pwdata[4:0];
        REG_STRIDE_EXP: stride_exp_q <= pwdata[3:0];
        REG_BLOCK_LOG2: block_log2_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_QUEUE_ID:   prdata = {24'd0, queue_id_q};
      REG_RING_SIZE:  prdata = {27'd0, ring_size_q};
      REG_STRIDE_EXP: prdata = {28'd0, stride_exp_q};
      REG_BLOCK_LOG2: prdata = {28'd0, block_log2_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg.queue_id   = queue_id_q;
  assign cfg.ring_size  = ring_size_q;
  assign cfg.stride_exp = stride_exp_q;

  nhqp_front #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .lba_i             (lba_i),
    .block_count_i     (block_count_i),
    .phase_bit_i       (phase_bit_i),
    .block_size_log2_i (block_log2_q),
    .fifo_full_i       (fifo_full),
    .push_o            (push),
    .entry_o           (push_entry)
  );

  nhqp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  nhqp_back #(
    .MAX_QUEUE_DEPTH (MAX_QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .entry_i     (head_entry),
    .empty_i     (fifo_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o            = res.kind;
  assign doorbell_write_o  = res.db_write;
  assign doorbell_offset_o = res.db_offset;
  assign doorbell_value_o  = res.db_value;
  assign opcode_o          = res.opcode;
  assign command_id_o      = res.command_id;
  assign start_block_o     = res.start_block;
  assign count_minus_one_o = res.cnt_m1;
  assign slot_o            = res.slot;

endmodule

// ----- rtl/nhqp_front.sv -----
// ----------------------------------------------------------------------------
// nhqp_front
// accepts request beats and classifies them: function, size and page checks
// ----------------------------------------------------------------------------
module nhqp_front #(
  parameter int PAGE_BYTES = nhqp_pkg::DEF_PAGE_BYTES
) (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [1:0]      func_i,
  input  logic [63:0]     lba_i,
  input  logic [15:0]     block_count_i,
  input  logic            phase_bit_i,
  input  logic [3:0]      block_size_log2_i,
  input  logic            fifo_full_i,
  output logic            push_o,
  output nhqp_pkg::entry_t entry_o
);
  import nhqp_pkg::*;

  logic [3:0]  lg;
  logic [28:0] xfer_bytes;

  // block size clamped to 512..4096
  always_comb begin
    if (block_size_log2_i < 4'd9) begin
      lg = 4'd9;
    end else if (block_size_log2_i > 4'd12) begin
      lg = 4'd12;
    end else begin
      lg = block_size_log2_i;
    end
  end

  assign xfer_bytes = {13'd0, block_count_i} << lg;

  always_comb begin
    entry_o         = '0;
    entry_o.lba     = lba_i;
    entry_o.cnt_m1  = block_count_i - 16'd1;
    entry_o.phase   = phase_bit_i;
    entry_o.xfer_ok = (block_count_i != 16'd0) && (xfer_bytes <= 29'(PAGE_BYTES));
    case (func_i)
      FUNC_READ: begin
        entry_o.cls    = CLS_SUBMIT;
        entry_o.opcode = OPC_READ;
      end
      FUNC_WRITE: begin
        entry_o.cls    = CLS_SUBMIT;
        entry_o.opcode = OPC_WRITE;
      end
      FUNC_COMPL: begin
        entry_o.cls    = CLS_COMPL;
        entry_o.opcode = OPC_NONE;
      end
      default: begin
        entry_o.cls    = CLS_BAD;
        entry_o.opcode = OPC_NONE;
      end
    endcase
  end

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

endmodule

// ----- rtl/nhqp_fifo.sv -----
// ----------------------------------------------------------------------------
// nhqp_fifo
// short queue of classified beats between front and back
// ----------------------------------------------------------------------------
module nhqp_fifo #(
  parameter int DEPTH = nhqp_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  nhqp_pkg::entry_t entry_i,
  input  logic             pop_i,
  output nhqp_pkg::entry_t entry_o,
  output logic             full_o,
  output logic             empty_o
);
  import nhqp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/nhqp_back.sv -----
// ----------------------------------------------------------------------------
// nhqp_back
// ring pointers, phase and outstanding count; builds the result beat
// ----------------------------------------------------------------------------
module nhqp_back #(
  parameter int MAX_QUEUE_DEPTH = nhqp_pkg::DEF_MAX_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nhqp_pkg::cfg_t    cfg_i,
  input  nhqp_pkg::entry_t  entry_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nhqp_pkg::result_t res_o
);
  import nhqp_pkg::*;

  localparam int RING_TOP = (MAX_QUEUE_DEPTH > 16) ? 16 :
                            ((MAX_QUEUE_DEPTH < 2) ? 2 : MAX_QUEUE_DEPTH);

  logic [3:0]  sq_tail_q, sq_tail_d;
  logic [3:0]  cq_head_q, cq_head_d;
  logic        cq_phase_q, cq_phase_d;
  logic [4:0]  outst_q, outst_d;
  logic [15:0] next_id_q, next_id_d;
  logic        valid_q;
  result_t     res_q, res_d;

  logic [4:0]  ring_n, ring_last;
  logic [4:0]  tail_inc, head_inc;
  logic [8:0]  sq_idx, cq_idx;
  logic [4:0]  shamt;
  logic [25:0] sq_db, cq_db;
  logic        load;

  always_comb begin
    if (cfg_i.ring_size > 5'(RING_TOP)) begin
      ring_n = 5'(RING_TOP);
    end else if (cfg_i.ring_size < 5'd2) begin
      ring_n = 5'd2;
    end else begin
      ring_n = cfg_i.ring_size;
    end
  end

  assign ring_last = ring_n - 5'd1;
  assign tail_inc  = {1'b0, sq_tail_q} + 5'd1;
  assign head_inc  = {1'b0, cq_head_q} + 5'd1;

  // doorbell offset: base plus (2*qid + which) * (4 << stride_exp)
  assign sq_idx = {cfg_i.queue_id, 1'b0};
  assign cq_idx = {cfg_i.queue_id, 1'b1};
  assign shamt  = {1'b0, cfg_i.stride_exp} + 5'd2;
  assign sq_db  = DB_BASE + ({17'd0, sq_idx} << shamt);
  assign cq_db  = DB_BASE + ({17'd0, cq_idx} << shamt);

  assign load  = !valid_q || !out_stall_i;
  assign pop_o = load && !empty_i;

  always_comb begin
    sq_tail_d  = sq_tail_q;
    cq_head_d  = cq_head_q;
    cq_phase_d = cq_phase_q;
    outst_d    = outst_q;
    next_id_d  = next_id_q;
    res_d      = '0;
    case (entry_i.cls)
      CLS_SUBMIT: begin
        if (!entry_i.xfer_ok || outst_q >= ring_last) begin
          res_d.kind = KIND_REJECTED;
        end else begin
          sq_tail_d         = (tail_inc > ring_last) ? 4'd0 : tail_inc[3:0];
          outst_d           = outst_q + 5'd1;
          next_id_d         = next_id_q + 16'd1;
          res_d.kind        = KIND_ISSUED;
          res_d.opcode      = entry_i.opcode;
          res_d.command_id  = next_id_q;
          res_d.start_block = entry_i.lba;
          res_d.cnt_m1      = entry_i.cnt_m1;
          res_d.slot        = sq_tail_q;
          res_d.db_write    = 1'b1;
          res_d.db_offset   = sq_db;
          res_d.db_value    = sq_tail_d;
        end
      end
      CLS_COMPL: begin
        if (entry_i.phase == cq_phase_q || outst_q == 5'd0) begin
          res_d.kind = KIND_STALE;
        end else begin
          res_d.kind = KIND_CONSUMED;
          if (head_inc > ring_last) begin
            cq_head_d  = 4'd0;
            cq_phase_d = !cq_phase_q;
          end else begin
            cq_head_d = head_inc[3:0];
          end
          outst_d = outst_q - 5'd1;
          // head doorbell only once the queue drains
          if (outst_d == 5'd0) begin
            res_d.db_write  = 1'b1;
            res_d.db_offset = cq_db;
            res_d.db_value  = cq_head_d;
          end
        end
      end
      default: begin
        res_d.kind = KIND_REJECTED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_tail_q  <= '0;
      cq_head_q  <= '0;
      cq_phase_q <= 1'b0;
      outst_q    <= '0;
      next_id_q  <= '0;
      valid_q    <= 1'b0;
    end else begin
      if (pop_o) begin
        sq_tail_q  <= sq_tail_d;
        cq_head_q  <= cq_head_d;
        cq_phase_q <= cq_phase_d;
        outst_q    <= outst_d;
        next_id_q  <= next_id_d;
      end
      if (load) begin
        valid_q <= !empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/nhqp_checker.sv -----
// ----------------------------------------------------------------------------
// nhqp_checker
// port-level checks of the queue pair engine, bound to the top level
// ----------------------------------------------------------------------------
`include "nvme_host_queue_pair_engine_unit_macros.svh"

module nhqp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic        doorbell_write_o,
  input logic [1:0]  opcode_o,
  input logic [15:0] command_id_o
);
  import nhqp_pkg::*;

  // a stalled result beat holds
  `NHQP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(command_id_o), "result beat changed under stall")

  // an issued command always rings the tail doorbell with a real opcode
  `NHQP_ASSERT(a_issue_db, out_valid_o && kind_o == KIND_ISSUED |-> doorbell_write_o && opcode_o != OPC_NONE, "issued command without doorbell or opcode")

  // rejects and stale entries carry no doorbell and no opcode
  `NHQP_ASSERT(a_nop_quiet, out_valid_o && (kind_o == KIND_REJECTED || kind_o == KIND_STALE) |-> !doorbell_write_o && opcode_o == OPC_NONE, "reject or stale beat carries a command")

  // no result beat in the first cycle out of reset
  `NHQP_ASSERT_ALWAYS(a_rst_idle, $rose(rst_ni) |-> !out_valid_o, "result valid right out of reset")

endmodule

bind nvme_host_queue_pair_engine_unit nhqp_checker u_nhqp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .kind_o           (kind_o),
  .doorbell_write_o (doorbell_write_o),
  .opcode_o         (opcode_o),
  .command_id_o     (command_id_o)
);
